// ===== hdl/opwfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opwfr_pkg
// Shared widths, register indexes and bundles for the pulse-width receiver.
// ----------------------------------------------------------------------------
package opwfr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int SPLIT_BITS  = 31;
    localparam int BYTE_BITS   = 8;
    localparam int LEFT_BITS   = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 31;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LIGHT_THRESHOLD = 3'd0,
        REG_PULSE_SPLIT     = 3'd1,
        REG_BEGIN_ONE       = 3'd2,
        REG_BEGIN_TWO       = 3'd3,
        REG_END_ONE         = 3'd4,
        REG_END_TWO         = 3'd5
    } cfg_reg_t;

    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(2048);
    localparam logic [SPLIT_BITS-1:0]  SPLIT_RESET     = SPLIT_BITS'(1000);
    localparam logic [BYTE_BITS-1:0]   BEGIN_ONE_RESET = 8'd126;
    localparam logic [BYTE_BITS-1:0]   BEGIN_TWO_RESET = 8'd129;
    localparam logic [BYTE_BITS-1:0]   END_ONE_RESET   = 8'd129;
    localparam logic [BYTE_BITS-1:0]   END_TWO_RESET   = 8'd126;

    // Frame marker set handed to the framer
    typedef struct packed {
        logic [BYTE_BITS-1:0] begin_one;
        logic [BYTE_BITS-1:0] begin_two;
        logic [BYTE_BITS-1:0] end_one;
        logic [BYTE_BITS-1:0] end_two;
    } marker_cfg_t;

    // Bit window as it stands after the current sample
    typedef struct packed {
        logic                 new_bit;
        logic [BYTE_BITS-1:0] window;
    } bit_info_t;

endpackage
`default_nettype wire

// ===== hdl/opwfr_edge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opwfr_edge
// Light pulse detector: times each pulse and shifts the decoded bit in.
// ----------------------------------------------------------------------------
module opwfr_edge
    import opwfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [TIME_BITS-1:0]   timestamp,
    input  wire logic [SAMPLE_BITS-1:0] light_threshold,
    input  wire logic [SPLIT_BITS-1:0]  pulse_split,
    output bit_info_t                   bits
);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_RISE = 2'd1,
        PH_WAIT_FALL = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [BYTE_BITS-1:0]   shift_reg, shift_next;
    logic [TIME_BITS-1:0]   span;
    logic                   bit_zero;
    logic                   new_bit;

    assign span = timestamp - start_reg;
    // Negative span never exceeds the split
    assign bit_zero = !span[TIME_BITS-1]
                      && (SPLIT_BITS'(span[TIME_BITS-2:0]) > pulse_split);

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        shift_next = shift_reg;
        new_bit    = 1'b0;
        unique case (phase_reg)
            PH_WAIT_FALL:
            begin
                if (sample < light_threshold)
                begin
                    phase_next = PH_WAIT_RISE;
                    shift_next = {shift_reg[BYTE_BITS-2:0], !bit_zero};
                    new_bit    = 1'b1;
                end
            end
            default:
            begin
                if (sample > light_threshold)
                begin
                    phase_next = PH_WAIT_FALL;
                    start_next = timestamp;
                end
            end
        endcase
    end

    assign bits = {new_bit, shift_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            start_reg <= '0;
            shift_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            shift_reg <= shift_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/opwfr_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opwfr_framer
// Byte framer: hunts both begin markers, then emits bytes up to the end pair.
// ----------------------------------------------------------------------------
module opwfr_framer
    import opwfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire bit_info_t            bits,
    input  wire marker_cfg_t          markers,
    output logic                      emit,
    output logic [BYTE_BITS-1:0]      emit_byte,
    output logic                      emit_end
);

    typedef enum logic [1:0] {
        FR_HUNT_ONE = 2'd1,
        FR_HUNT_TWO = 2'd2,
        FR_IN_FRAME = 2'd3
    } frame_t;

    frame_t                 phase_reg, phase_next;
    logic [LEFT_BITS-1:0]   left_reg, left_next, left_dec;
    logic [BYTE_BITS-1:0]   prev_reg, prev_next;
    logic [BYTE_BITS-1:0]   win;

    assign win = bits.window;
    assign left_dec = (bits.new_bit && left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_dec;
        prev_next  = prev_reg;
        emit       = 1'b0;
        emit_end   = 1'b0;
        priority if (phase_reg == FR_HUNT_ONE && win == markers.begin_one)
        begin
            left_next  = LEFT_BITS'(BYTE_BITS);
            phase_next = FR_HUNT_TWO;
            prev_next  = win;
        end
        else if (left_dec == '0 && phase_reg == FR_HUNT_TWO && win == markers.begin_two)
        begin
            left_next  = LEFT_BITS'(BYTE_BITS);
            phase_next = FR_IN_FRAME;
            prev_next  = win;
        end
        else if (left_dec == '0 && phase_reg == FR_IN_FRAME)
        begin
            emit = 1'b1;
            if (win == markers.end_two && prev_reg == markers.end_one)
            begin
                // End pair complete: keep prev, drop back to the first hunt
                left_next  = '0;
                phase_next = FR_HUNT_ONE;
                emit_end   = 1'b1;
            end
            else
            begin
                left_next = LEFT_BITS'(BYTE_BITS);
                prev_next = win;
            end
        end
        else
        begin
        end
    end

    assign emit_byte = win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FR_HUNT_ONE;
            left_reg  <= '0;
            prev_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            prev_reg  <= prev_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/optical_pulse_width_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// optical_pulse_width_frame_receiver
// Decodes pulse-width modulated light samples into framed bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : sample, timestamp with sample_valid / sample_stall. A word
//                    is taken on a rising edge with valid high and stall low.
//   Output channel : rx_byte, frame_end with result_valid / result_stall.
//                    Only samples that complete a frame byte give a word.
//   Config channel : cfg_index, cfg_data with cfg_valid / cfg_ready; ready is
//                    always high, unknown indexes are ignored. Write only
//                    while the block is idle.
//   Output timing  : a result word is registered and appears in the cycle after its sample.
//   Throughput     : one sample per cycle while sample_stall is low; all decoding
//                    of a sample is done in the cycle it is taken, set by the
//                    timestamp subtract and split compare feeding the framer.
//   Reset          : rst_n clears pulse detector, bit window and framer, and
//                    loads the default threshold, split and markers.
//   Stall          : the result register holds its word while result_stall
//                    is high; a new sample is then refused only if the
//                    register is full, otherwise intake carries on.
// ----------------------------------------------------------------------------
module optical_pulse_width_frame_receiver
    import opwfr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     sample_valid,
    output logic                          sample_stall,
    input  wire logic [SAMPLE_BITS-1:0]   sample,
    input  wire logic [TIME_BITS-1:0]     timestamp,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic [BYTE_BITS-1:0]          rx_byte,
    output logic                          frame_end,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [SPLIT_BITS-1:0]  split_reg;
    marker_cfg_t            markers_reg;

    logic                   accept;
    bit_info_t              bits;
    logic                   emit;
    logic [BYTE_BITS-1:0]   emit_byte;
    logic                   emit_end;

    logic                   valid_reg;
    logic [BYTE_BITS-1:0]   byte_reg;
    logic                   end_reg;
    logic                   out_load;

    // Configuration registers: always ready, out-of-range indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg         <= THRESHOLD_RESET;
            split_reg             <= SPLIT_RESET;
            markers_reg.begin_one <= BEGIN_ONE_RESET;
            markers_reg.begin_two <= BEGIN_TWO_RESET;
            markers_reg.end_one   <= END_ONE_RESET;
            markers_reg.end_two   <= END_TWO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LIGHT_THRESHOLD: threshold_reg         <= cfg_data[SAMPLE_BITS-1:0];
                REG_PULSE_SPLIT:     split_reg             <= cfg_data[SPLIT_BITS-1:0];
                REG_BEGIN_ONE:       markers_reg.begin_one <= cfg_data[BYTE_BITS-1:0];
                REG_BEGIN_TWO:       markers_reg.begin_two <= cfg_data[BYTE_BITS-1:0];
                REG_END_ONE:         markers_reg.end_one   <= cfg_data[BYTE_BITS-1:0];
                REG_END_TWO:         markers_reg.end_two   <= cfg_data[BYTE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Refuse a sample only when the result register is full and held
    assign sample_stall = valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;

    opwfr_edge u_edge (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .sample          (sample),
        .timestamp       (timestamp),
        .light_threshold (threshold_reg),
        .pulse_split     (split_reg),
        .bits            (bits)
    );

    opwfr_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .bits      (bits),
        .markers   (markers_reg),
        .emit      (emit),
        .emit_byte (emit_byte),
        .emit_end  (emit_end)
    );

    // Result register: advance whenever it is empty or being taken
    assign out_load = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && accept && emit)
        begin
            byte_reg <= emit_byte;
            end_reg  <= emit_end;
        end
    end

    assign result_valid = valid_reg;
    assign rx_byte      = byte_reg;
    assign frame_end    = end_reg;

endmodule
`default_nettype wire
